### src/float_format_converter_defines.svh
// Assertion macros for the floating-point format converter.
// Included by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef FLOAT_FORMAT_CONVERTER_DEFINES_SVH
`define FLOAT_FORMAT_CONVERTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ffc_pkg.sv
// Shared types, constants and helper functions for the floating-point format converter.
// Used by every pipeline stage module and by the top level.
package ffc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned KIND_W = 2;

    localparam logic [31:0] F32_EXP_INF = 32'h7F80_0000;
    localparam logic [15:0] F16_EXP_INF = 16'h7C00;
    localparam logic [7:0]  F32_EXP_MAX = 8'hFF;
    localparam logic [4:0]  F16_EXP_MAX = 5'h1F;
    localparam logic [7:0]  F32_EXP_OVER = 8'd142;
    localparam logic [7:0]  F32_EXP_NORM = 8'd113;
    localparam logic [7:0]  EXP_REBIAS = 8'd112;

    typedef enum logic [KIND_W-1:0] {
        KIND_H2F = 2'd0,
        KIND_F2H = 2'd1,
        KIND_B2F = 2'd2,
        KIND_F2B = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] value;
        logic              h_exp_zero;
        logic              h_exp_max;
        logic              h_man_zero;
        logic              f_over;
        logic              f_norm;
    } t_stage1;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] value;
        logic              h_exp_zero;
        logic              h_exp_max;
        logic              h_man_zero;
        logic [3:0]        shifts;
        logic [15:0]       half_word;
    } t_stage2;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] converted;
    } t_result;

    // Left shifts needed to bring the leading one of a half subnormal mantissa to bit 10.
    function automatic logic [3:0] ffc_norm_shift(input logic [9:0] man);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                n = 4'(10 - i);
            end
        end
        return n;
    endfunction

endpackage

### src/ffc_unpack.sv
// First pipeline stage: splits the source pattern into fields and classifies them.
// Depends on ffc_pkg.
module ffc_unpack (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  ffc_pkg::t_kind           i_kind,
    input  logic [31:0]              i_value,
    output logic                     o_valid,
    output ffc_pkg::t_stage1         o_data
);
    import ffc_pkg::*;

    logic    r_valid;
    t_stage1 r_data;
    t_stage1 n_data;

    always_comb begin
        n_data.kind       = i_kind;
        n_data.value      = i_value;
        n_data.h_exp_zero = (i_value[14:10] == 5'd0);
        n_data.h_exp_max  = (i_value[14:10] == F16_EXP_MAX);
        n_data.h_man_zero = (i_value[9:0] == 10'd0);
        n_data.f_over     = (i_value[30:23] > F32_EXP_OVER);
        n_data.f_norm     = (i_value[30:23] >= F32_EXP_NORM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/ffc_classify.sv
// Second pipeline stage: counts the normalising shift of half subnormals and
// forms the single-to-half result. Depends on ffc_pkg.
module ffc_classify (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  ffc_pkg::t_stage1         i_data,
    output logic                     o_valid,
    output ffc_pkg::t_stage2         o_data
);
    import ffc_pkg::*;

    logic    r_valid;
    t_stage2 r_data;
    t_stage2 n_data;
    logic [7:0] f_exp_half;

    always_comb begin
        f_exp_half        = i_data.value[30:23] - EXP_REBIAS;
        n_data.kind       = i_data.kind;
        n_data.value      = i_data.value;
        n_data.h_exp_zero = i_data.h_exp_zero;
        n_data.h_exp_max  = i_data.h_exp_max;
        n_data.h_man_zero = i_data.h_man_zero;
        n_data.shifts     = ffc_norm_shift(i_data.value[9:0]);
        if (i_data.f_over) begin
            n_data.half_word = {i_data.value[31], 15'd0} | F16_EXP_INF;
        end else if (i_data.f_norm) begin
            n_data.half_word = {i_data.value[31], f_exp_half[4:0], i_data.value[22:13]};
        end else begin
            n_data.half_word = {i_data.value[31], 15'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/ffc_pack.sv
// Third pipeline stage: normalises half subnormals, packs the single result
// and selects the output for the chosen conversion. Depends on ffc_pkg.
module ffc_pack (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  ffc_pkg::t_stage2         i_data,
    output logic                     o_valid,
    output ffc_pkg::t_result         o_data
);
    import ffc_pkg::*;

    logic    r_valid;
    t_result r_data;
    t_result n_data;
    logic [31:0] single_word;
    logic [9:0]  man_norm;
    logic [7:0]  exp_sub;
    logic [7:0]  exp_norm;

    always_comb begin
        man_norm = i_data.value[9:0] << i_data.shifts;
        exp_sub  = F32_EXP_NORM - {4'd0, i_data.shifts};
        exp_norm = {3'd0, i_data.value[14:10]} + EXP_REBIAS;
        if (i_data.h_exp_zero && i_data.h_man_zero) begin
            single_word = {i_data.value[15], 31'd0};
        end else if (i_data.h_exp_zero) begin
            single_word = {i_data.value[15], exp_sub, man_norm, 13'd0};
        end else if (i_data.h_exp_max) begin
            single_word = {i_data.value[15], 8'd0, i_data.value[9:0], 13'd0} | F32_EXP_INF;
        end else begin
            single_word = {i_data.value[15], exp_norm, i_data.value[9:0], 13'd0};
        end

        n_data.kind = i_data.kind;
        case (i_data.kind)
            KIND_H2F: n_data.converted = single_word;
            KIND_F2H: n_data.converted = {16'd0, i_data.half_word};
            KIND_B2F: n_data.converted = {i_data.value[15:0], 16'd0};
            KIND_F2B: n_data.converted = {16'd0, i_data.value[31:16]};
            default:  n_data.converted = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/float_format_converter.sv
// Top level of the floating-point format converter: three register stages
// with per-stage stall control. Depends on ffc_pkg, ffc_unpack, ffc_classify, ffc_pack.
//
// Channel   Direction  Transaction contents
// s_axis    in         tuser: kind (2 bits); tdata: value (32 bits)
// m_axis    out        tdata: converted (32 bits)
//
// An accepted transaction moves in order through the unpack, classify and pack stage registers.
// Takes one transaction per cycle unless stalled, as a stage loads if free or its next moves on.
// Reset is synchronous and active low and empties all three stages.
// A stalled output holds its transaction while earlier stages keep filling empty slots.
`include "float_format_converter_defines.svh"

module float_format_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] converted
);
    import ffc_pkg::*;

    logic    s1_valid;
    logic    s2_valid;
    logic    s3_valid;
    logic    s1_en;
    logic    s2_en;
    logic    s3_en;
    t_stage1 s1_data;
    t_stage2 s2_data;
    t_result s3_data;
    logic    pipe_full;
    logic    s3_narrow;
    logic    s_accept;

    assign s3_en = !s3_valid || i_m_axis_tready;
    assign s2_en = !s2_valid || s3_en;
    assign s1_en = !s1_valid || s2_en;

    ffc_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_en),
        .i_valid (i_s_axis_tvalid),
        .i_kind  (t_kind'(i_s_axis_tuser)),
        .i_value (i_s_axis_tdata),
        .o_valid (s1_valid),
        .o_data  (s1_data)
    );

    ffc_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s2_en),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    ffc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s3_en),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .o_data  (s3_data)
    );

    assign o_s_axis_tready = s1_en;
    assign o_m_axis_tvalid = s3_valid;
    assign o_m_axis_tdata  = s3_data.converted;

    assign pipe_full = s1_valid && s2_valid && s3_valid;
    assign s3_narrow = s3_valid && (s3_data.kind == KIND_F2H || s3_data.kind == KIND_F2B);
    assign s_accept  = i_s_axis_tvalid && o_s_axis_tready;

    `FFC_ASSERT_NOW(a_full_when_stalled, !o_s_axis_tready, pipe_full, "stall with a free stage")
    `FFC_ASSERT_NOW(a_narrow_upper_zero, s3_narrow, s3_data.converted[31:16] == 16'd0, "no zero fill")
    `FFC_ASSERT_NEXT(a_fill_from_input, !s1_valid && !s_accept, !s1_valid, "stage one filled unasked")

endmodule

### dv/float_format_converter_test.sv
// Self-checking testbench for float_format_converter: a directed table, then random
// conversions of all four kinds, checked against a behavioural predictor in this file.
// Depends on ffc_pkg for the conversion kind; needs nothing but the RTL.
module float_format_converter_test;
    import ffc_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RANDOM_ITEMS = 700;
    localparam int DIRECTED_ROWS = 23;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic        known;
        logic [31:0] result;
    } t_vector;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_value = '0;
    logic [1:0]  s_kind = '0;
    logic        m_ready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [31:0] o_m_axis_tdata;

    logic [31:0] pending_results[$];
    int          error_count = 0;
    int          burst_left = 0;
    logic [8:0]  stall_phase = '0;

    t_vector directed_rows [DIRECTED_ROWS] = '{
        '{KIND_H2F, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{KIND_H2F, 32'h0000_8000, 1'b1, 32'h8000_0000},
        '{KIND_H2F, 32'h0000_7C00, 1'b1, 32'h7F80_0000},
        '{KIND_H2F, 32'h0000_FC00, 1'b1, 32'hFF80_0000},
        '{KIND_H2F, 32'h0000_3C00, 1'b1, 32'h3F80_0000},
        '{KIND_H2F, 32'h0000_7E01, 1'b0, 32'h0},
        '{KIND_H2F, 32'h0000_0001, 1'b0, 32'h0},
        '{KIND_H2F, 32'h0000_83FF, 1'b0, 32'h0},
        '{KIND_H2F, 32'hFFFF_7BFF, 1'b0, 32'h0},
        '{KIND_F2H, 32'h7F80_0000, 1'b1, 32'h0000_7C00},
        '{KIND_F2H, 32'hFFC0_0000, 1'b1, 32'h0000_FC00},
        '{KIND_F2H, 32'h4780_0000, 1'b1, 32'h0000_7C00},
        '{KIND_F2H, 32'h477F_FFFF, 1'b0, 32'h0},
        '{KIND_F2H, 32'hB880_0000, 1'b0, 32'h0},
        '{KIND_F2H, 32'h387F_FFFF, 1'b1, 32'h0000_0000},
        '{KIND_F2H, 32'h8000_0001, 1'b1, 32'h0000_8000},
        '{KIND_F2H, 32'h3F80_0000, 1'b1, 32'h0000_3C00},
        '{KIND_F2H, 32'h3FFF_FFFF, 1'b0, 32'h0},
        '{KIND_B2F, 32'hABCD_FFFF, 1'b1, 32'hFFFF_0000},
        '{KIND_B2F, 32'hFFFF_0000, 1'b1, 32'h0000_0000},
        '{KIND_F2B, 32'hFFFF_FFFF, 1'b1, 32'h0000_FFFF},
        '{KIND_F2B, 32'h7FC0_0001, 1'b1, 32'h0000_7FC0},
        '{KIND_F2B, 32'h0000_0000, 1'b1, 32'h0000_0000}
    };

    float_format_converter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_value),   // [31:0] value
        .i_s_axis_tuser  (s_kind),    // [1:0] kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)   // [31:0] converted
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [31:0] convert_pattern(input t_kind kind, input logic [31:0] value);
        logic        sign;
        logic [7:0]  wide_exp;
        logic [4:0]  half_exp;
        logic [9:0]  half_man;
        int          lead;
        logic [31:0] result;
        result = '0;
        case (kind)
            KIND_H2F: begin
                sign = value[15];
                half_exp = value[14:10];
                half_man = value[9:0];
                if (half_exp == 5'd0 && half_man == 10'd0) begin
                    result = {sign, 31'd0};
                end else if (half_exp == 5'd0) begin
                    lead = 0;
                    for (int i = 0; i < 10; i++) begin
                        if (half_man[i]) begin
                            lead = i;
                        end
                    end
                    result = {sign, 8'(103 + lead), 10'(half_man << (10 - lead)), 13'd0};
                end else if (half_exp == 5'h1F) begin
                    result = {sign, 8'hFF, half_man, 13'd0};
                end else begin
                    result = {sign, 8'(half_exp + 8'd112), half_man, 13'd0};
                end
            end
            KIND_F2H: begin
                sign = value[31];
                wide_exp = value[30:23];
                if (wide_exp > 8'd142) begin
                    result = {16'd0, sign, 5'h1F, 10'd0};
                end else if (wide_exp >= 8'd113) begin
                    result = {16'd0, sign, 5'(wide_exp - 8'd112), value[22:13]};
                end else begin
                    result = {16'd0, sign, 15'd0};
                end
            end
            KIND_B2F: result = {value[15:0], 16'd0};
            default:  result = {16'd0, value[31:16]};
        endcase
        return result;
    endfunction

    // Biases the source pattern towards the exponent boundaries of each kind.
    function automatic logic [31:0] shape_value(input t_kind kind);
        logic [31:0] value;
        logic [7:0]  wide_exp;
        value = $urandom;
        case (kind)
            KIND_H2F: begin
                case ($urandom_range(0, 4))
                    0: value[14:10] = 5'd0;
                    1: value[14:10] = 5'h1F;
                    2: value[9:0] = 10'd1 << $urandom_range(0, 9);
                    3: value[14:0] = '0;
                    default: ;
                endcase
            end
            KIND_F2H: begin
                case ($urandom_range(0, 5))
                    0: wide_exp = 8'($urandom_range(110, 145));
                    1: wide_exp = 8'd0;
                    2: wide_exp = 8'hFF;
                    3: wide_exp = 8'($urandom_range(0, 3) + 8'd112 + 8'($urandom_range(0, 1) * 29));
                    default: wide_exp = value[30:23];
                endcase
                value[30:23] = wide_exp;
            end
            default: begin
                if ($urandom_range(0, 5) == 0) begin
                    value[30:23] = 8'hFF;
                end
            end
        endcase
        return value;
    endfunction

    task automatic report_mismatch(input string text);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, text);
    endtask

    task automatic send_transaction(input t_kind kind, input logic [31:0] value,
                                    input logic [31:0] result);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        pending_results.push_back(result);
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        burst_left--;
    endtask

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 9'd1;
        case (stall_phase[8:7])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= (stall_phase[2:0] == 3'd0);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, converted %h", o_m_axis_tdata));
            end else begin
                if (o_m_axis_tdata !== pending_results[0]) begin
                    report_mismatch($sformatf("converted %h, expected %h",
                                              o_m_axis_tdata, pending_results[0]));
                end
                void'(pending_results.pop_front());
            end
        end
    end

    initial begin
        t_kind       kind;
        logic [31:0] value;
        int          waited;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[n]) begin
            send_transaction(directed_rows[n].kind, directed_rows[n].value,
                             directed_rows[n].known ? directed_rows[n].result
                             : convert_pattern(directed_rows[n].kind, directed_rows[n].value));
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = t_kind'($urandom_range(0, 3));
            value = ($urandom_range(0, 3) == 0) ? 32'($urandom) : shape_value(kind);
            send_transaction(kind, value, convert_pattern(kind, value));
        end
        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d transactions never arrived", pending_results.size()));
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
